/* sv/gqi_pkg.sv */
// Shared types, constants and the product schedule for the gyro quaternion integrator.
package gqi_pkg;

    localparam int QW      = 32;           // quaternion component width
    localparam int RW      = 24;           // gyro rate width
    localparam int MUL_AW  = 40;           // serial multiplier, parallel operand
    localparam int MUL_BW  = 32;           // serial multiplier, bit-serial operand
    localparam int MUL_PW  = MUL_AW + MUL_BW;
    localparam int ROOT_W  = 32;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int DIV_DW  = 32;
    localparam int DIV_NW  = 2 * DIV_DW;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ERR    = 2'd1;
    localparam logic [1:0] ST_BAD_DT = 2'd2;

    localparam logic REQ_SYNC = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    localparam logic [26:0]        DEG2RAD_Q32 = 27'd74961321;
    localparam logic [63:0]        NORM_SQ_MIN = 64'd7205759;
    localparam logic signed [31:0] ONE_Q28     = 32'sd268435456;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] quat_w_in;
        logic signed [31:0] quat_x_in;
        logic signed [31:0] quat_y_in;
        logic signed [31:0] quat_z_in;
        logic signed [23:0] rate_x_in;
        logic signed [23:0] rate_y_in;
        logic signed [23:0] rate_z_in;
        logic [7:0]         sensor_flags_in;
        logic [23:0]        step_time;
    } gqi_req_t;

    typedef struct packed {
        logic [1:0]         result_status;
        logic signed [31:0] quat_w_out;
        logic signed [31:0] quat_x_out;
        logic signed [31:0] quat_y_out;
        logic signed [31:0] quat_z_out;
        logic [7:0]         sensor_flags_out;
    } gqi_rsp_t;

    // One cross term of q (x) (0, a): target component, q source, angle axis, minus sign
    typedef struct packed {
        logic [1:0] dest;
        logic [1:0] src;
        logic [1:0] axis;
        logic       neg;
    } gqi_term_t;

    localparam int N_TERMS = 12;

    function automatic gqi_term_t term_sel(input logic [3:0] j);
        gqi_term_t t;
        unique case (j)
            4'd0:    t = '{dest: 2'd0, src: 2'd1, axis: 2'd0, neg: 1'b1};
            4'd1:    t = '{dest: 2'd0, src: 2'd2, axis: 2'd1, neg: 1'b1};
            4'd2:    t = '{dest: 2'd0, src: 2'd3, axis: 2'd2, neg: 1'b1};
            4'd3:    t = '{dest: 2'd1, src: 2'd0, axis: 2'd0, neg: 1'b0};
            4'd4:    t = '{dest: 2'd1, src: 2'd2, axis: 2'd2, neg: 1'b0};
            4'd5:    t = '{dest: 2'd1, src: 2'd3, axis: 2'd1, neg: 1'b1};
            4'd6:    t = '{dest: 2'd2, src: 2'd0, axis: 2'd1, neg: 1'b0};
            4'd7:    t = '{dest: 2'd2, src: 2'd1, axis: 2'd2, neg: 1'b1};
            4'd8:    t = '{dest: 2'd2, src: 2'd3, axis: 2'd0, neg: 1'b0};
            4'd9:    t = '{dest: 2'd3, src: 2'd0, axis: 2'd2, neg: 1'b0};
            4'd10:   t = '{dest: 2'd3, src: 2'd1, axis: 2'd1, neg: 1'b0};
            4'd11:   t = '{dest: 2'd3, src: 2'd2, axis: 2'd0, neg: 1'b1};
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

/* sv/gqi_serial_mul.sv */
// Unsigned shift-add multiplier, one multiplier bit per cycle.
module gqi_serial_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gqi_pkg::MUL_AW-1:0]  a,
    input  logic [gqi_pkg::MUL_BW-1:0]  b,
    output logic                        done,
    output logic [gqi_pkg::MUL_PW-1:0]  prod
);
    import gqi_pkg::*;

    localparam int CW = $clog2(MUL_BW);
    localparam logic [CW-1:0] LAST = CW'(MUL_BW - 1);

    logic [MUL_AW-1:0] a_reg;
    logic [MUL_PW-1:0] prod_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [MUL_AW:0]   sum;

    // upper half accumulates, lower half shifts out the multiplier bits
    assign sum = {1'b0, prod_reg[MUL_PW-1:MUL_BW]}
               + (prod_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            prod_reg <= {{MUL_AW{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            prod_reg <= {sum, prod_reg[MUL_BW-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;
endmodule

/* sv/gqi_serial_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
module gqi_serial_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gqi_pkg::RAD_W-1:0]   radicand,
    output logic                        done,
    output logic [gqi_pkg::ROOT_W-1:0]  root
);
    import gqi_pkg::*;

    localparam int CW = $clog2(ROOT_W);
    localparam logic [CW-1:0] LAST = CW'(ROOT_W - 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              ge;

    assign rem_sh = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

/* sv/gqi_serial_div.sv */
// Restoring divider, one quotient bit per cycle; numerator high half must be below divisor.
module gqi_serial_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gqi_pkg::DIV_NW-1:0]  numer,
    input  logic [gqi_pkg::DIV_DW-1:0]  denom,
    output logic                        done,
    output logic [gqi_pkg::DIV_DW-1:0]  quot
);
    import gqi_pkg::*;

    localparam int CW = $clog2(DIV_DW);
    localparam logic [CW-1:0] LAST = CW'(DIV_DW - 1);

    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] nq_reg;     // numerator bits out, quotient bits in
    logic [DIV_DW-1:0] d_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   diff;
    logic              ge;

    assign rem_sh = {rem_reg, nq_reg[DIV_DW-1]};
    assign diff   = rem_sh - {1'b0, d_reg};
    assign ge     = (rem_sh >= {1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= numer[DIV_NW-1:DIV_DW];
            nq_reg  <= numer[DIV_DW-1:0];
            d_reg   <= denom;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
            nq_reg  <= {nq_reg[DIV_DW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = nq_reg;
endmodule

/* sv/gyro_quaternion_integrator.sv */
// Gyro quaternion integrator: sequencer, state and bit-serial arithmetic units.
//
//  channel | signals                  | direction | transfer when
//  --------+--------------------------+-----------+--------------------------
//  req     | req_valid req_ready req  | in        | req_valid & req_ready
//  rsp     | rsp_valid rsp_ready rsp  | out       | rsp_valid & rsp_ready
//
// One item at a time; every multiply goes through one shift-add unit at one
// bit per cycle, plus a hand-off for each product.
// Integrate: 6 angle products, 12 cross products, up to 8 squares, a root,
// 4 divides and the scaling shifts.
// Sync: magnitudes, norm test and, below 2^30, squares; zero step time: no arithmetic.
// A finished result waits in the rsp register while the next req is taken.
// Reset loads the unit quaternion and clears rates and flags.
module gyro_quaternion_integrator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  gqi_pkg::gqi_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output gqi_pkg::gqi_rsp_t rsp
);
    import gqi_pkg::*;

    localparam int PW = 38;     // width of the unnormalized sum

    typedef enum logic [3:0] {
        S_IDLE, S_HA_RATE, S_HA_DT, S_QMUL, S_TO_MAG, S_TEST, S_SQ_CHK,
        S_SCALE_DN, S_SCALE_UP, S_SQ_NORM, S_SQRT, S_DIV, S_DONE
    } state_t;

    state_t                state_reg, state_next;
    gqi_req_t              req_reg, req_next;
    logic signed [QW-1:0]  orient_reg [4];
    logic signed [QW-1:0]  orient_next [4];
    logic signed [RW-1:0]  rate_reg [3];
    logic signed [RW-1:0]  rate_next [3];
    logic [7:0]            flags_reg, flags_next;
    logic signed [PW-1:0]  p_reg [4];
    logic signed [PW-1:0]  p_next [4];
    logic                  psign_reg [4];
    logic                  psign_next [4];
    logic [PW-1:0]         pmag_reg [4];
    logic [PW-1:0]         pmag_next [4];
    logic                  ha_sign_reg [3];
    logic                  ha_sign_next [3];
    logic [31:0]           ha_mag_reg [3];
    logic [31:0]           ha_mag_next [3];
    logic [34:0]           wmag_reg, wmag_next;
    logic [63:0]           sum_reg, sum_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [3:0]            idx_reg, idx_next;
    logic                  launched_reg, launched_next;
    logic [1:0]            status_reg, status_next;
    gqi_rsp_t              rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic [MUL_AW-1:0]     mul_a;
    logic [MUL_BW-1:0]     mul_b;
    logic                  mul_start, mul_done;
    logic [MUL_PW-1:0]     mul_prod;
    logic                  sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]     sqrt_root;
    logic                  div_start, div_done;
    logic [DIV_NW-1:0]     div_numer;
    logic [DIV_DW-1:0]     div_quot;

    gqi_term_t             term;
    logic signed [QW-1:0]  src_val;
    logic [QW-1:0]         src_mag;
    logic signed [RW-1:0]  rate_val;
    logic [RW-1:0]         rate_mag;
    logic [50:0]           w_sum;
    logic [59:0]           h_sum;
    logic [38:0]           hmag;
    logic [31:0]           ha_sat;
    logic [63:0]           q_sum;
    logic signed [PW-1:0]  term_ext;
    logic                  term_neg;
    logic signed [PW-1:0]  p_upd;
    logic [63:0]           sum_add;
    logic [DIV_DW-1:0]     div_res;
    logic                  big_any, big2_any, low_all;
    logic                  arith_mul;
    logic                  do_commit;

    assign term     = term_sel(idx_reg);
    assign src_val  = orient_reg[term.src];
    assign src_mag  = src_val[QW-1] ? (~src_val + 1'b1) : src_val;
    assign rate_val = rate_reg[idx_reg[1:0]];
    assign rate_mag = rate_val[RW-1] ? (~rate_val + 1'b1) : rate_val;

    // rad/s in Q.24 from deg/s, then half angle in Q.28, both rounded
    assign w_sum  = {1'b0, mul_prod[49:0]} + 51'd32768;
    assign h_sum  = {1'b0, mul_prod[58:0]} + (60'd1 << 20);
    assign hmag   = h_sum[59:21];
    always_comb
    begin
        if (!rate_val[RW-1])
            ha_sat = (hmag > 39'h7FFFFFFF) ? 32'h7FFFFFFF : hmag[31:0];
        else
            ha_sat = (hmag > 39'h80000000) ? 32'h80000000 : hmag[31:0];
    end

    assign q_sum    = {1'b0, mul_prod[62:0]} + (64'd1 << 27);
    assign term_ext = {2'b00, q_sum[63:28]};
    assign term_neg = src_val[QW-1] ^ ha_sign_reg[term.axis] ^ term.neg;
    assign p_upd    = term_neg ? (p_reg[term.dest] - term_ext)
                               : (p_reg[term.dest] + term_ext);
    assign sum_add  = sum_reg + mul_prod[63:0];

    assign big_any  = (pmag_reg[0][PW-1:30] != '0) || (pmag_reg[1][PW-1:30] != '0)
                   || (pmag_reg[2][PW-1:30] != '0) || (pmag_reg[3][PW-1:30] != '0);
    assign big2_any = (pmag_reg[0][PW-1:31] != '0) || (pmag_reg[1][PW-1:31] != '0)
                   || (pmag_reg[2][PW-1:31] != '0) || (pmag_reg[3][PW-1:31] != '0);
    assign low_all  = (pmag_reg[0][PW-1:29] == '0) && (pmag_reg[1][PW-1:29] == '0)
                   && (pmag_reg[2][PW-1:29] == '0) && (pmag_reg[3][PW-1:29] == '0);

    // v * 2^28 + n / 2, then round-to-nearest quotient
    assign div_numer = (DIV_NW'(pmag_reg[idx_reg[1:0]][30:0]) << 28)
                     + DIV_NW'(root_reg[ROOT_W-1:1]);
    always_comb
    begin
        if (!psign_reg[idx_reg[1:0]])
            div_res = (div_quot > 32'h7FFFFFFF) ? 32'h7FFFFFFF : div_quot;
        else
            div_res = (div_quot > 32'h80000000) ? 32'h80000000 : (~div_quot + 1'b1);
    end

    always_comb
    begin
        unique case (state_reg)
            S_HA_RATE:
            begin
                mul_a = MUL_AW'(DEG2RAD_Q32);
                mul_b = MUL_BW'(rate_mag);
            end
            S_HA_DT:
            begin
                mul_a = MUL_AW'(wmag_reg);
                mul_b = MUL_BW'(req_reg.step_time);
            end
            S_QMUL:
            begin
                mul_a = MUL_AW'(src_mag);
                mul_b = ha_mag_reg[term.axis];
            end
            S_SQ_CHK, S_SQ_NORM:
            begin
                mul_a = MUL_AW'(pmag_reg[idx_reg[1:0]]);
                mul_b = pmag_reg[idx_reg[1:0]][MUL_BW-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign arith_mul  = (state_reg == S_HA_RATE) || (state_reg == S_HA_DT)
                     || (state_reg == S_QMUL) || (state_reg == S_SQ_CHK)
                     || (state_reg == S_SQ_NORM);
    assign mul_start  = !launched_reg && arith_mul;
    assign sqrt_start = !launched_reg && (state_reg == S_SQRT);
    assign div_start  = !launched_reg && (state_reg == S_DIV);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        orient_next    = orient_reg;
        rate_next      = rate_reg;
        flags_next     = flags_reg;
        p_next         = p_reg;
        psign_next     = psign_reg;
        pmag_next      = pmag_reg;
        ha_sign_next   = ha_sign_reg;
        ha_mag_next    = ha_mag_reg;
        wmag_next      = wmag_reg;
        sum_next       = sum_reg;
        root_next      = root_reg;
        idx_next       = idx_reg;
        launched_next  = launched_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        do_commit      = 1'b0;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req;
                    status_next = ST_OK;
                    if (req.req_type == REQ_SYNC)
                    begin
                        p_next[0]  = PW'(req.quat_w_in);
                        p_next[1]  = PW'(req.quat_x_in);
                        p_next[2]  = PW'(req.quat_y_in);
                        p_next[3]  = PW'(req.quat_z_in);
                        state_next = S_TO_MAG;
                    end
                    else if (req.step_time == '0)
                    begin
                        status_next = ST_BAD_DT;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_HA_RATE;
                    end
                end
            end
            S_HA_RATE:
            begin
                if (!launched_reg)
                    launched_next = 1'b1;
                else if (mul_done)
                begin
                    launched_next = 1'b0;
                    wmag_next     = w_sum[50:16];
                    state_next    = S_HA_DT;
                end
            end
            S_HA_DT:
            begin
                if (!launched_reg)
                    launched_next = 1'b1;
                else if (mul_done)
                begin
                    launched_next                = 1'b0;
                    ha_sign_next[idx_reg[1:0]]   = rate_val[RW-1];
                    ha_mag_next[idx_reg[1:0]]    = ha_sat;
                    if (idx_reg == 4'd2)
                    begin
                        idx_next = '0;
                        for (int i = 0; i < 4; i++)
                            p_next[i] = PW'(orient_reg[i]);
                        state_next = S_QMUL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_HA_RATE;
                    end
                end
            end
            S_QMUL:
            begin
                if (!launched_reg)
                    launched_next = 1'b1;
                else if (mul_done)
                begin
                    launched_next       = 1'b0;
                    p_next[term.dest]   = p_upd;
                    if (idx_reg == 4'(N_TERMS - 1))
                        state_next = S_TO_MAG;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            S_TO_MAG:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    psign_next[i] = p_reg[i][PW-1];
                    pmag_next[i]  = p_reg[i][PW-1] ? (~p_reg[i] + 1'b1) : p_reg[i];
                end
                state_next = S_TEST;
            end
            S_TEST:
            begin
                // a component at 2^30 or more passes the norm test outright
                if (big_any)
                begin
                    if (req_reg.req_type == REQ_SYNC)
                    begin
                        do_commit  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_SCALE_DN;
                end
                else
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = S_SQ_CHK;
                end
            end
            S_SQ_CHK:
            begin
                if (!launched_reg)
                    launched_next = 1'b1;
                else if (mul_done)
                begin
                    launched_next = 1'b0;
                    sum_next      = sum_add;
                    if (idx_reg == 4'd3)
                    begin
                        if (sum_add > NORM_SQ_MIN)
                        begin
                            if (req_reg.req_type == REQ_SYNC)
                            begin
                                do_commit  = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                                state_next = S_SCALE_UP;
                        end
                        else
                        begin
                            status_next = ST_ERR;
                            state_next  = S_DONE;
                        end
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            S_SCALE_DN:
            begin
                // truncate while two or more shifts remain, round on the last
                for (int i = 0; i < 4; i++)
                begin
                    if (big2_any)
                        pmag_next[i] = pmag_reg[i] >> 1;
                    else
                        pmag_next[i] = PW'(({1'b0, pmag_reg[i]} + 1'b1) >> 1);
                end
                if (!big2_any)
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = S_SQ_NORM;
                end
            end
            S_SCALE_UP:
            begin
                if (low_all)
                begin
                    for (int i = 0; i < 4; i++)
                        pmag_next[i] = pmag_reg[i] << 1;
                end
                else
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = S_SQ_NORM;
                end
            end
            S_SQ_NORM:
            begin
                if (!launched_reg)
                    launched_next = 1'b1;
                else if (mul_done)
                begin
                    launched_next = 1'b0;
                    sum_next      = sum_add;
                    if (idx_reg == 4'd3)
                        state_next = S_SQRT;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            S_SQRT:
            begin
                if (!launched_reg)
                    launched_next = 1'b1;
                else if (sqrt_done)
                begin
                    launched_next = 1'b0;
                    root_next     = sqrt_root;
                    idx_next      = '0;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!launched_reg)
                    launched_next = 1'b1;
                else if (div_done)
                begin
                    launched_next             = 1'b0;
                    orient_next[idx_reg[1:0]] = div_res;
                    if (idx_reg == 4'd3)
                        state_next = S_DONE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.result_status    = status_reg;
                    rsp_next.quat_w_out       = orient_reg[0];
                    rsp_next.quat_x_out       = orient_reg[1];
                    rsp_next.quat_y_out       = orient_reg[2];
                    rsp_next.quat_z_out       = orient_reg[3];
                    rsp_next.sensor_flags_out = flags_reg;
                    rsp_valid_next            = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_commit)
        begin
            orient_next[0] = req_reg.quat_w_in;
            orient_next[1] = req_reg.quat_x_in;
            orient_next[2] = req_reg.quat_y_in;
            orient_next[3] = req_reg.quat_z_in;
            rate_next[0]   = req_reg.rate_x_in;
            rate_next[1]   = req_reg.rate_y_in;
            rate_next[2]   = req_reg.rate_z_in;
            flags_next     = req_reg.sensor_flags_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            orient_reg[0] <= ONE_Q28;
            orient_reg[1] <= '0;
            orient_reg[2] <= '0;
            orient_reg[3] <= '0;
            for (int i = 0; i < 3; i++)
            begin
                rate_reg[i]    <= '0;
                ha_sign_reg[i] <= 1'b0;
                ha_mag_reg[i]  <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                p_reg[i]     <= '0;
                psign_reg[i] <= 1'b0;
                pmag_reg[i]  <= '0;
            end
            flags_reg     <= '0;
            wmag_reg      <= '0;
            sum_reg       <= '0;
            root_reg      <= '0;
            idx_reg       <= '0;
            launched_reg  <= 1'b0;
            status_reg    <= ST_OK;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            orient_reg    <= orient_next;
            rate_reg      <= rate_next;
            ha_sign_reg   <= ha_sign_next;
            ha_mag_reg    <= ha_mag_next;
            p_reg         <= p_next;
            psign_reg     <= psign_next;
            pmag_reg      <= pmag_next;
            flags_reg     <= flags_next;
            wmag_reg      <= wmag_next;
            sum_reg       <= sum_next;
            root_reg      <= root_next;
            idx_reg       <= idx_next;
            launched_reg  <= launched_next;
            status_reg    <= status_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    gqi_serial_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start),
        .a        (mul_a),
        .b        (mul_b),
        .done     (mul_done),
        .prod     (mul_prod)
    );

    gqi_serial_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    gqi_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (root_reg),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // one item in flight: a transfer on req takes the sequencer out of idle
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("req taken twice in a row");

    // after scaling the sum of squares lies in [2^58, 2^62], so the root is at least 2^29
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (sqrt_root >= (ROOT_W'(1) << 29)))
        else $error("norm root below scaled range");

    // each component magnitude is at most the root, so the quotient never passes one
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (div_quot <= (DIV_DW'(1) << 28)))
        else $error("normalized component above one");
endmodule

/* dv/tb_gyro_quaternion_integrator.sv */
// Self-checking testbench for the gyro quaternion integrator: directed table plus random items.
`timescale 1ns / 100ps

module tb_gyro_quaternion_integrator;
    import gqi_pkg::*;

    localparam int N_RANDOM   = 1900;
    localparam int STALL_MAX  = 20000;
    localparam int DRAIN_WAIT = 1500;

    typedef struct {
        gqi_req_t req;
        bit       typed;
        gqi_rsp_t rsp;
    } stim_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    gqi_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    gqi_rsp_t rsp;

    gqi_rsp_t  expected_rsp[$];
    int        err_count = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 0;
    int        rsp_stall_pct = 0;
    stim_row_t stim_table[$];

    // orientation model state
    longint att_w, att_x, att_y, att_z;
    longint gyro_x, gyro_y, gyro_z;
    logic [7:0] flags_q;

    gyro_quaternion_integrator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    function automatic longint unsigned abs64(longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    // round to nearest, ties away from zero
    function automatic longint rnd_shift(longint x, int n);
        longint unsigned m;
        m = (abs64(x) + (64'd1 << (n - 1))) >> n;
        return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint rnd_div(longint x, longint unsigned d);
        longint unsigned m;
        m = (abs64(x) + d / 2) / d;
        return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned peak_mag(longint p[4]);
        longint unsigned m;
        m = 0;
        for (int i = 0; i < 4; i++) if (abs64(p[i]) > m) m = abs64(p[i]);
        return m;
    endfunction

    function automatic bit norm_passes(longint p[4]);
        longint unsigned s;
        s = 0;
        if (peak_mag(p) >= (64'd1 << 30)) return 1'b1;
        for (int i = 0; i < 4; i++) s += abs64(p[i]) * abs64(p[i]);
        return s > NORM_SQ_MIN;
    endfunction

    function automatic longint half_angle(longint rate, longint dt);
        longint w;
        w = rnd_shift(rate * longint'(DEG2RAD_Q32), 16);
        return clamp32(rnd_shift(w * dt, 21));
    endfunction

    function automatic longint qmul(longint a, longint b);
        return rnd_shift(a * b, 28);
    endfunction

    // advance the orientation state by one item, return the expected response
    function automatic gqi_rsp_t predict_orientation(gqi_req_t r);
        longint p[4];
        longint v[4];
        longint ax, ay, az;
        longint unsigned m, s, n;
        int k;
        logic [1:0] st;
        st = ST_OK;
        if (r.req_type == REQ_SYNC)
        begin
            p[0] = longint'(r.quat_w_in); p[1] = longint'(r.quat_x_in);
            p[2] = longint'(r.quat_y_in); p[3] = longint'(r.quat_z_in);
            if (norm_passes(p))
            begin
                att_w = p[0]; att_x = p[1]; att_y = p[2]; att_z = p[3];
                gyro_x = longint'(r.rate_x_in);
                gyro_y = longint'(r.rate_y_in);
                gyro_z = longint'(r.rate_z_in);
                flags_q = r.sensor_flags_in;
            end
            else
            begin
                st = ST_ERR;
            end
        end
        else if (r.step_time == 0)
        begin
            st = ST_BAD_DT;
        end
        else
        begin
            ax = half_angle(gyro_x, longint'(r.step_time));
            ay = half_angle(gyro_y, longint'(r.step_time));
            az = half_angle(gyro_z, longint'(r.step_time));
            // all four terms from the old quaternion
            p[0] = att_w - qmul(att_x, ax) - qmul(att_y, ay) - qmul(att_z, az);
            p[1] = att_x + qmul(att_w, ax) + qmul(att_y, az) - qmul(att_z, ay);
            p[2] = att_y + qmul(att_w, ay) - qmul(att_x, az) + qmul(att_z, ax);
            p[3] = att_z + qmul(att_w, az) + qmul(att_x, ay) - qmul(att_y, ax);
            if (norm_passes(p))
            begin
                m = peak_mag(p);
                k = 0;
                if (m >= (64'd1 << 30))
                begin
                    while ((m >> k) >= (64'd1 << 30)) k++;
                    for (int i = 0; i < 4; i++) v[i] = rnd_shift(p[i], k);
                end
                else
                begin
                    while ((m << k) < (64'd1 << 29)) k++;
                    for (int i = 0; i < 4; i++) v[i] = p[i] * (64'sd1 << k);
                end
                s = 0;
                for (int i = 0; i < 4; i++) s += abs64(v[i]) * abs64(v[i]);
                n = int_sqrt(s);
                att_w = clamp32(rnd_div(v[0] * (64'sd1 << 28), n));
                att_x = clamp32(rnd_div(v[1] * (64'sd1 << 28), n));
                att_y = clamp32(rnd_div(v[2] * (64'sd1 << 28), n));
                att_z = clamp32(rnd_div(v[3] * (64'sd1 << 28), n));
            end
            else
            begin
                st = ST_ERR;
            end
        end
        return '{result_status: st, quat_w_out: att_w[31:0], quat_x_out: att_x[31:0],
                 quat_y_out: att_y[31:0], quat_z_out: att_z[31:0],
                 sensor_flags_out: flags_q};
    endfunction

    function automatic gqi_req_t mk_req(logic t, longint w, longint x, longint y, longint z,
                                        longint rx, longint ry, longint rz,
                                        logic [7:0] f, logic [23:0] dt);
        gqi_req_t r;
        r.req_type = t;
        r.quat_w_in = w[31:0]; r.quat_x_in = x[31:0];
        r.quat_y_in = y[31:0]; r.quat_z_in = z[31:0];
        r.rate_x_in = rx[23:0]; r.rate_y_in = ry[23:0]; r.rate_z_in = rz[23:0];
        r.sensor_flags_in = f;
        r.step_time = dt;
        return r;
    endfunction

    function automatic logic [31:0] rand_component();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'(ONE_Q28);
            2:       return 32'($signed($urandom_range(0, 4000)) - 2000);
            3:       return 32'd0;
            default: return 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
        endcase
    endfunction

    function automatic logic [23:0] rand_rate();
        case ($urandom_range(0, 3))
            0:       return 24'($urandom);
            1:       return 24'($signed($urandom_range(0, 1024)) - 512);
            default: return 24'($signed($urandom_range(0, 512000)) - 256000);
        endcase
    endfunction

    function automatic gqi_req_t rand_req();
        gqi_req_t r;
        r = '0;
        r.req_type = ($urandom_range(0, 99) < 55) ? REQ_STEP : REQ_SYNC;
        r.quat_w_in = rand_component(); r.quat_x_in = rand_component();
        r.quat_y_in = rand_component(); r.quat_z_in = rand_component();
        r.rate_x_in = rand_rate(); r.rate_y_in = rand_rate(); r.rate_z_in = rand_rate();
        r.sensor_flags_in = 8'($urandom);
        case ($urandom_range(0, 9))
            0:       r.step_time = 24'd0;
            1:       r.step_time = 24'($urandom);
            2:       r.step_time = 24'hFF_FFFF;
            default: r.step_time = 24'($urandom_range(1, 40000));
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, longint exp_v, longint got_v);
        $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
        err_count++;
    endtask

    task automatic send_item(gqi_req_t r, bit typed, gqi_rsp_t typed_rsp);
        gqi_rsp_t pred;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req = r;
        do @(posedge clk); while (!req_ready);
        pred = predict_orientation(r);
        expected_rsp.push_back(typed ? typed_rsp : pred);
        @(negedge clk);
    endtask

    always @(negedge clk) rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: response transfer with nothing expected", $realtime);
                err_count++;
            end
            else
            begin
                gqi_rsp_t e;
                e = expected_rsp.pop_front();
                if (rsp.result_status !== e.result_status)
                    report_mismatch("result_status", longint'(e.result_status),
                                    longint'(rsp.result_status));
                if (rsp.quat_w_out !== e.quat_w_out)
                    report_mismatch("quat_w_out", longint'(e.quat_w_out),
                                    longint'(rsp.quat_w_out));
                if (rsp.quat_x_out !== e.quat_x_out)
                    report_mismatch("quat_x_out", longint'(e.quat_x_out),
                                    longint'(rsp.quat_x_out));
                if (rsp.quat_y_out !== e.quat_y_out)
                    report_mismatch("quat_y_out", longint'(e.quat_y_out),
                                    longint'(rsp.quat_y_out));
                if (rsp.quat_z_out !== e.quat_z_out)
                    report_mismatch("quat_z_out", longint'(e.quat_z_out),
                                    longint'(rsp.quat_z_out));
                if (rsp.sensor_flags_out !== e.sensor_flags_out)
                    report_mismatch("sensor_flags_out", longint'(e.sensor_flags_out),
                                    longint'(rsp.sensor_flags_out));
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        gqi_rsp_t unit_rsp;
        gqi_rsp_t none_rsp;
        int per_phase;
        none_rsp = '0;
        unit_rsp = '{result_status: ST_OK, quat_w_out: ONE_Q28, quat_x_out: 0,
                     quat_y_out: 0, quat_z_out: 0, sensor_flags_out: 8'h00};
        att_w = ONE_Q28; att_x = 0; att_y = 0; att_z = 0;
        gyro_x = 0; gyro_y = 0; gyro_z = 0; flags_q = '0;

        // directed rows; typed ones follow straight from the reset state
        unit_rsp.result_status = ST_BAD_DT;
        stim_table.push_back('{mk_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, unit_rsp});
        unit_rsp.result_status = ST_ERR;
        stim_table.push_back('{mk_req(REQ_SYNC, 0, 0, 0, 0, 100, 100, 100, 8'hFF, 0),
                               1, unit_rsp});
        unit_rsp.result_status = ST_OK;
        stim_table.push_back('{mk_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 24'hFF_FFFF),
                               1, unit_rsp});
        unit_rsp.result_status = ST_ERR;
        // just below the norm threshold
        stim_table.push_back('{mk_req(REQ_SYNC, 1342, 1342, -1342, 1342, 5, 5, 5, 8'h5A, 0),
                               1, unit_rsp});
        // just above it
        stim_table.push_back('{mk_req(REQ_SYNC, 1343, 1343, -1343, 1343, 5, -5, 5, 8'hA5, 1),
                               0, none_rsp});
        stim_table.push_back('{mk_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0, none_rsp});
        stim_table.push_back('{mk_req(REQ_SYNC, 2147483647, 2147483647, 2147483647,
                                      2147483647, 8388607, 8388607, 8388607, 8'hFF, 0),
                               0, none_rsp});
        stim_table.push_back('{mk_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 24'hFF_FFFF),
                               0, none_rsp});
        stim_table.push_back('{mk_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 24'h00_0001),
                               0, none_rsp});
        stim_table.push_back('{mk_req(REQ_SYNC, -2147483648, -2147483648, -2147483648,
                                      -2147483648, -8388608, -8388608, -8388608, 8'h00,
                                      24'hFF_FFFF), 0, none_rsp});
        stim_table.push_back('{mk_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 24'hFF_FFFF),
                               0, none_rsp});
        stim_table.push_back('{mk_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_rsp});
        stim_table.push_back('{mk_req(REQ_SYNC, ONE_Q28, 0, 0, 0, 23040, -11520, 2560,
                                      8'h81, 0), 0, none_rsp});
        stim_table.push_back('{mk_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 24'd16777),
                               0, none_rsp});
        stim_table.push_back('{mk_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 24'd8388608),
                               0, none_rsp});
        stim_table.push_back('{mk_req(REQ_SYNC, 0, 0, 0, 1073741824, 0, 0, 0, 8'h3C, 0),
                               0, none_rsp});
        stim_table.push_back('{mk_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 24'd1000),
                               0, none_rsp});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_table[i]) send_item(stim_table[i].req, stim_table[i].typed,
                                          stim_table[i].rsp);

        per_phase = N_RANDOM / 4;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;  rsp_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 87; rsp_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  rsp_stall_pct = 87;
                end
                default:
                begin
                    send_idle_pct = 30; rsp_stall_pct = 30;
                end
            endcase
            for (int n = 0; n < per_phase; n++)
            begin
                send_item(rand_req(), 0, none_rsp);
                // pause the sender until everything is back, now and then
                if (n == per_phase / 2)
                begin
                    req_valid = 1'b0;
                    while (expected_rsp.size() != 0) @(negedge clk);
                end
            end
        end
        req_valid = 1'b0;

        while (expected_rsp.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (err_count == 0 && expected_rsp.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
